>>> hdl/dfsd_pkg.sv
// Shared types, constants and helpers for the duplicate frame skip detector.
`timescale 1ns / 1ps
`default_nettype none

package dfsd_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 262144;

    localparam int BYTE_W   = 8;
    localparam int POS_W    = 24;
    localparam int GEN_W    = 32;
    localparam int STREAK_W = 8;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // register map, selected by paddr[2]
    localparam logic REG_SKIP_ENABLE = 1'b0;
    localparam logic REG_MAX_STREAK  = 1'b1;

    // frame end context, sampled with each beat
    typedef struct packed {
        logic             geom_changed;
        logic [GEN_W-1:0] dirty_gen;
        logic             ff_active;
        logic             pres_dropping;
        logic             sound_on;
        logic             must_show;
    } t_ctx;

    // beat as it leaves the position stage
    typedef struct packed {
        logic last;
        logic no_frame;
        logic inv;      // snapshot invalidated by the size check
        logic pos_nz;   // frame was partly received
        logic failed;   // frame failed, as known after this beat
        t_ctx ctx;
    } t_beat;

    typedef struct packed {
        logic skip;
        logic duplicate;
    } t_result;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

`default_nettype wire

>>> hdl/duplicate_frame_skip_detector.sv
// Duplicate frame skip detector top level: stream ports, register port, pipeline.
// Throughput: one beat per cycle when s_axis_tready is high; the snapshot memory does one
// read and one write a cycle. A final beat is registered in the position stage; its result
// waits in a four-entry queue; s_axis_tready drops only when that queue could overflow.
// Reset is synchronous, active low: control state and registers clear, the
// snapshot memory is not cleared and starts invalid.
`timescale 1ns / 1ps
`default_nettype none

module duplicate_frame_skip_detector #(
    parameter int MAX_FRAME_BYTES = dfsd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] pixel_byte, [31:8] frame_bytes, [32] geom_changed, [64:33] dirty_gen,
    // [65] ff_active, [66] pres_dropping, [67] sound_on, [68] must_show
    input  logic [71:0] s_axis_tdata,
    input  logic        s_axis_tlast,   // last_of_frame
    input  logic        s_axis_tuser,   // [0] no_frame
    // stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] duplicate, [1] skip
    output logic [7:0]  m_axis_tdata,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dfsd_pkg::*;

    localparam int AddrW = addr_w(MAX_FRAME_BYTES);

    logic                r_skip_enable;
    logic [STREAK_W-1:0] r_max_streak;
    logic                cfg_wr;

    logic                in_accept;
    t_ctx                ctx;
    logic                mem_en;
    logic [AddrW-1:0]    mem_addr;
    logic                beat_vld;
    t_beat               beat;
    logic                mismatch;
    logic                res_push;
    t_result             res;
    t_result             out_res;
    logic [2:0]          fifo_cnt;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_enable <= 1'b0;
            r_max_streak  <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_SKIP_ENABLE: r_skip_enable <= pwdata[0];
                REG_MAX_STREAK:  r_max_streak  <= pwdata[STREAK_W-1:0];
                default:         r_skip_enable <= r_skip_enable;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SKIP_ENABLE: prdata = {31'b0, r_skip_enable};
            REG_MAX_STREAK:  prdata = {{(32-STREAK_W){1'b0}}, r_max_streak};
            default:         prdata = '0;
        endcase
    end

    // room for the beat in flight and the one taken now
    assign s_axis_tready = !((fifo_cnt == 3'd4) || ((fifo_cnt == 3'd3) && res_push));
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign ctx.geom_changed  = s_axis_tdata[32];
    assign ctx.dirty_gen     = s_axis_tdata[64:33];
    assign ctx.ff_active     = s_axis_tdata[65];
    assign ctx.pres_dropping = s_axis_tdata[66];
    assign ctx.sound_on      = s_axis_tdata[67];
    assign ctx.must_show     = s_axis_tdata[68];

    dfsd_ctrl #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_frame_bytes (s_axis_tdata[31:8]),
        .i_last        (s_axis_tlast),
        .i_no_frame    (s_axis_tuser),
        .i_ctx         (ctx),
        .o_mem_en      (mem_en),
        .o_mem_addr    (mem_addr),
        .o_beat_vld    (beat_vld),
        .o_beat        (beat)
    );

    dfsd_snap #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_snap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (mem_en),
        .i_addr     (mem_addr),
        .i_byte     (s_axis_tdata[7:0]),
        .o_mismatch (mismatch)
    );

    dfsd_decide u_decide (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_beat_vld    (beat_vld),
        .i_beat        (beat),
        .i_mismatch    (mismatch),
        .i_skip_enable (r_skip_enable),
        .i_max_streak  (r_max_streak),
        .o_push        (res_push),
        .o_result      (res)
    );

    dfsd_res_fifo u_res_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res_push),
        .i_data   (res),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_data   (out_res),
        .o_count  (fifo_cnt)
    );

    assign m_axis_tdata = {6'b0, out_res.skip, out_res.duplicate};

    // queue never written when full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> (fifo_cnt != 3'd4))
        else $error("result queue overflow");

    // a result follows only a final or frameless beat taken the cycle before
    a_push_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> $past(in_accept && (s_axis_tlast || s_axis_tuser)))
        else $error("result without frame end");

    // only a duplicate frame is ever skipped
    a_skip_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[1] && !m_axis_tdata[0]))
        else $error("skip on non-duplicate frame");

endmodule

`default_nettype wire

>>> hdl/dfsd_ctrl.sv
// Position stage: size checks, snapshot address and per-beat frame status.
`timescale 1ns / 1ps
`default_nettype none

module dfsd_ctrl #(
    parameter int MAX_FRAME_BYTES = dfsd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_accept,
    input  logic [dfsd_pkg::POS_W-1:0]                     i_frame_bytes,
    input  logic                                           i_last,
    input  logic                                           i_no_frame,
    input  dfsd_pkg::t_ctx                                 i_ctx,
    output logic                                           o_mem_en,
    output logic [dfsd_pkg::addr_w(MAX_FRAME_BYTES)-1:0]   o_mem_addr,
    output logic                                           o_beat_vld,
    output dfsd_pkg::t_beat                                o_beat
);
    import dfsd_pkg::*;

    localparam int AddrW = addr_w(MAX_FRAME_BYTES);
    localparam logic [POS_W-1:0] MaxBytes = POS_W'(MAX_FRAME_BYTES);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_size, n_size;
    logic             r_failed, n_failed;
    logic             r_beat_vld;
    t_beat            r_beat, n_beat;

    logic             first, size_bad, failed_a, in_range, failed_b, cnt_bad;
    logic [POS_W-1:0] size_a;

    always_comb begin
        first    = (r_pos == '0);
        size_bad = (i_frame_bytes == '0) || (i_frame_bytes > MaxBytes);
        failed_a = r_failed || (first && size_bad);
        size_a   = r_size;
        if (first) begin
            size_a = size_bad ? '0 : i_frame_bytes;
        end
        in_range = (r_pos < size_a) && (r_pos < MaxBytes);
        failed_b = failed_a || !in_range;
        cnt_bad  = ({1'b0, r_pos} + (POS_W+1)'(1)) != {1'b0, size_a};

        o_mem_en   = i_accept && !i_no_frame && !failed_a && in_range;
        o_mem_addr = r_pos[AddrW-1:0];

        n_beat.last     = i_last;
        n_beat.no_frame = i_no_frame;
        n_beat.inv      = first && (size_bad || (i_frame_bytes != r_size));
        n_beat.pos_nz   = !first;
        n_beat.failed   = failed_b || (i_last && cnt_bad);
        n_beat.ctx      = i_ctx;

        n_pos    = r_pos;
        n_size   = r_size;
        n_failed = r_failed;
        if (i_accept) begin
            if (i_no_frame) begin
                n_pos    = '0;
                n_failed = 1'b0;
            end else begin
                n_size = size_a;
                if (i_last) begin
                    n_pos    = '0;
                    n_failed = 1'b0;
                end else begin
                    n_failed = failed_b;
                    if (r_pos != POS_MAX) begin
                        n_pos = r_pos + POS_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_size     <= '0;
            r_failed   <= 1'b0;
            r_beat_vld <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_size     <= n_size;
            r_failed   <= n_failed;
            r_beat_vld <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat_vld = r_beat_vld;
    assign o_beat     = r_beat;

endmodule

`default_nettype wire

>>> hdl/dfsd_snap.sv
// Snapshot store: registered read, compare and write back in the cycle after the read.
`timescale 1ns / 1ps
`default_nettype none

module dfsd_snap #(
    parameter int MAX_FRAME_BYTES = dfsd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_rd_en,
    input  logic [dfsd_pkg::addr_w(MAX_FRAME_BYTES)-1:0]   i_addr,
    input  logic [dfsd_pkg::BYTE_W-1:0]                    i_byte,
    output logic                                           o_mismatch
);
    import dfsd_pkg::*;

    localparam int AddrW = addr_w(MAX_FRAME_BYTES);

    logic [BYTE_W-1:0] r_mem [MAX_FRAME_BYTES];

    logic              r_we;
    logic [AddrW-1:0]  r_addr;
    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] r_rdata;
    logic              r_fwd;
    logic [BYTE_W-1:0] r_fwd_byte;

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_mem[r_addr] <= r_byte;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_we <= 1'b0;
        end else begin
            r_we <= i_rd_en;
        end
    end

    // a read of the entry being written this cycle takes the byte in flight
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_addr     <= i_addr;
            r_byte     <= i_byte;
            r_fwd      <= r_we && (r_addr == i_addr);
            r_fwd_byte <= r_byte;
        end
    end

    assign o_mismatch = r_we && ((r_fwd ? r_fwd_byte : r_rdata) != r_byte);

endmodule

`default_nettype wire

>>> hdl/dfsd_decide.sv
// Frame end stage: snapshot validity, mismatch tracking and skip decision.
`timescale 1ns / 1ps
`default_nettype none

module dfsd_decide (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_beat_vld,
    input  dfsd_pkg::t_beat               i_beat,
    input  logic                          i_mismatch,
    input  logic                          i_skip_enable,
    input  logic [dfsd_pkg::STREAK_W-1:0] i_max_streak,
    output logic                          o_push,
    output dfsd_pkg::t_result             o_result
);
    import dfsd_pkg::*;

    logic                r_snap_valid, n_snap_valid;
    logic                r_mis, n_mis;
    logic [STREAK_W-1:0] r_streak, n_streak;
    logic [GEN_W-1:0]    r_gen, n_gen;

    logic valid_e, mis_e, dup, skip, frame_end;

    always_comb begin
        valid_e   = r_snap_valid && !i_beat.inv;
        mis_e     = r_mis || i_mismatch;
        frame_end = i_beat_vld && (i_beat.no_frame || i_beat.last);
        dup       = !i_beat.no_frame && !i_beat.failed && valid_e && !mis_e;
        skip      = i_skip_enable && dup && !i_beat.ctx.geom_changed
                    && (r_gen == i_beat.ctx.dirty_gen)
                    && !i_beat.ctx.ff_active && !i_beat.ctx.pres_dropping
                    && i_beat.ctx.sound_on && !i_beat.ctx.must_show
                    && (r_streak < i_max_streak);

        n_snap_valid = r_snap_valid;
        n_mis        = r_mis;
        n_streak     = r_streak;
        n_gen        = r_gen;
        if (i_beat_vld) begin
            if (i_beat.no_frame) begin
                if (i_beat.pos_nz && r_mis) begin
                    n_snap_valid = 1'b0;
                end
                n_mis = 1'b0;
            end else if (i_beat.last) begin
                n_snap_valid = !i_beat.failed;
                n_mis        = 1'b0;
            end else begin
                n_snap_valid = valid_e;
                n_mis        = mis_e;
            end
        end
        if (frame_end) begin
            if (skip) begin
                n_streak = r_streak + STREAK_W'(1);
            end else begin
                n_streak = '0;
                n_gen    = i_beat.ctx.dirty_gen;
            end
        end

        o_push             = frame_end;
        o_result.duplicate = dup;
        o_result.skip      = skip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
            r_mis        <= 1'b0;
            r_streak     <= '0;
            r_gen        <= '0;
        end else begin
            r_snap_valid <= n_snap_valid;
            r_mis        <= n_mis;
            r_streak     <= n_streak;
            r_gen        <= n_gen;
        end
    end

endmodule

`default_nettype wire

>>> hdl/dfsd_res_fifo.sv
// Four-entry result queue in front of the output stream.
`timescale 1ns / 1ps
`default_nettype none

module dfsd_res_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dfsd_pkg::t_result i_data,
    input  logic              i_tready,
    output logic              o_tvalid,
    output dfsd_pkg::t_result o_data,
    output logic [2:0]        o_count
);
    import dfsd_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic       pop;

    assign pop      = o_tvalid && i_tready;
    assign o_tvalid = (r_count != 3'd0);
    assign o_data   = r_mem[r_rd_ptr];
    assign o_count  = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 2'd1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + {2'b00, i_push} - {2'b00, pop};
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/dfsd_verdict_checker.sv
// Checker for the duplicate frame skip detector: mirrors the block and checks each verdict.
`timescale 1ns / 1ps

module dfsd_verdict_checker #(
    parameter int CAPACITY = dfsd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream, as seen on the block's slave side
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [71:0] i_in_data,
    input  logic        i_in_last,
    input  logic        i_in_user,
    // verdict stream
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_data,
    // register port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_error_count,
    output int          o_verdicts_owed
);
    import dfsd_pkg::*;

    // mirror of the snapshot; entries never written read as zero
    byte unsigned         shadow [int];
    logic [POS_W-1:0]     held_size;
    logic                 shadow_valid;
    logic [POS_W-1:0]     position;
    logic                 diff_seen;
    logic                 broken;
    logic [STREAK_W-1:0]  streak;
    logic [GEN_W-1:0]     synced_gen;
    logic                 skip_en;
    logic [STREAK_W-1:0]  streak_cap;
    t_result              owed [$];
    t_result              got;

    task automatic flag_error(input string what);
        $display("%0t ns  mismatch: %s", $time, what);
        o_error_count++;
    endtask

    // frame end: skip decision, streak and generation upkeep
    task automatic close_frame(input logic dup, input logic [71:0] d);
        t_result r;
        r.duplicate = dup;
        r.skip = skip_en && dup && !d[32] && (synced_gen == d[64:33]) && !d[65] && !d[66]
                 && d[67] && !d[68] && (streak < streak_cap);
        if (r.skip) begin
            streak = streak + 1'b1;
        end else begin
            streak     = '0;
            synced_gen = d[64:33];
        end
        owed.push_back(r);
    endtask

    task automatic take_beat(input logic [71:0] d, input logic last, input logic nof);
        logic [BYTE_W-1:0] px;
        logic [POS_W-1:0]  stated;
        logic [BYTE_W-1:0] held;
        logic              dup_now;
        px     = d[7:0];
        stated = d[31:8];
        if (nof) begin
            // a partial frame that already differed leaves the snapshot unusable
            if (position != 0 && diff_seen) shadow_valid = 1'b0;
            position  = '0;
            diff_seen = 1'b0;
            broken    = 1'b0;
            close_frame(1'b0, d);
            return;
        end
        if (position == 0) begin
            if (stated == 0 || stated > CAPACITY) begin
                broken       = 1'b1;
                held_size    = '0;
                shadow_valid = 1'b0;
            end else if (stated != held_size) begin
                held_size    = stated;
                shadow_valid = 1'b0;
            end
        end
        if (!broken) begin
            if (position < held_size && position < CAPACITY) begin
                held = shadow.exists(int'(position)) ? shadow[int'(position)] : 8'h00;
                if (held != px) diff_seen = 1'b1;
                shadow[int'(position)] = px;
            end else begin
                broken = 1'b1;
            end
        end
        if (!last) begin
            if (position != POS_MAX) position = position + 1'b1;
            return;
        end
        if ({1'b0, position} + 1'b1 != {1'b0, held_size}) broken = 1'b1;
        dup_now      = !broken && shadow_valid && !diff_seen;
        shadow_valid = !broken;
        position     = '0;
        diff_seen    = 1'b0;
        broken       = 1'b0;
        close_frame(dup_now, d);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow.delete();
            owed.delete();
            held_size    = '0;
            shadow_valid = 1'b0;
            position     = '0;
            diff_seen    = 1'b0;
            broken       = 1'b0;
            streak       = '0;
            synced_gen   = '0;
            skip_en      = 1'b0;
            streak_cap   = '0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[2])
                    REG_SKIP_ENABLE: skip_en = i_pwdata[0];
                    REG_MAX_STREAK:  streak_cap = i_pwdata[STREAK_W-1:0];
                endcase
            end
            if (i_in_valid && i_in_ready) take_beat(i_in_data, i_in_last, i_in_user);
            if (i_out_valid && i_out_ready) begin
                if (owed.size() == 0) begin
                    flag_error($sformatf("verdict %b arrived with none owed", i_out_data[1:0]));
                end else begin
                    got = owed.pop_front();
                    if (i_out_data[0] !== got.duplicate)
                        flag_error($sformatf("duplicate %b, predicted %b",
                                             i_out_data[0], got.duplicate));
                    if (i_out_data[1] !== got.skip)
                        flag_error($sformatf("skip %b, predicted %b", i_out_data[1], got.skip));
                end
            end
        end
        o_verdicts_owed = owed.size();
    end

endmodule

>>> tb/sv/duplicate_frame_skip_detector_tb.sv
// Testbench top for the duplicate frame skip detector: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module duplicate_frame_skip_detector_tb;
    import dfsd_pkg::*;

    localparam int CAPACITY       = MAX_FRAME_BYTES_DEF;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BEATS   = 800;
    localparam int PHASES         = 6;
    localparam logic [2:0] ADDR_SKIP_ENABLE = {REG_SKIP_ENABLE, 2'b00};
    localparam logic [2:0] ADDR_MAX_STREAK  = {REG_MAX_STREAK, 2'b00};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [7:0] pixel_byte, [31:8] frame_bytes, [32] geom_changed, [64:33] dirty_gen,
    // [65] ff_active, [66] pres_dropping, [67] sound_on, [68] must_show
    logic [71:0] s_axis_tdata;
    logic        s_axis_tlast;   // last_of_frame
    logic        s_axis_tuser;   // [0] no_frame
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [0] duplicate, [1] skip
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int           error_count;
    int           verdicts_owed;
    int           quiet_cycles = 0;
    int           beats_sent = 0;
    t_ctx         ctx;           // context carried by the closing beat of a frame
    byte unsigned img[];         // content of the frame most recently built
    bit           tx_steady = 1'b0;
    bit           rx_steady = 1'b0;
    bit           rx_hold = 1'b0;

    always #5 i_clk = ~i_clk;

    duplicate_frame_skip_detector #(
        .MAX_FRAME_BYTES(CAPACITY)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    dfsd_verdict_checker #(
        .CAPACITY(CAPACITY)
    ) verdict_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (s_axis_tvalid),
        .i_in_ready      (s_axis_tready),
        .i_in_data       (s_axis_tdata),
        .i_in_last       (s_axis_tlast),
        .i_in_user       (s_axis_tuser),
        .i_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .i_out_data      (m_axis_tdata),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_error_count   (error_count),
        .o_verdicts_owed (verdicts_owed)
    );

    // watchdog: too long without any beat or register access means a hang
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("duplicate_frame_skip_detector_tb: done, errors");
            $finish;
        end
    end

    // verdict receiver: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = rx_steady ? 0 : $urandom_range(0, 18);
            if (rx_hold) begin
                gap     = RX_HOLD_CYCLES;
                rx_hold = 1'b0;
            end
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_beat(input byte unsigned px, input logic [23:0] stated,
                             input bit last, input bit nof);
        int          gap;
        t_ctx        c;
        logic [63:0] noise;
        gap   = tx_steady ? 0 : $urandom_range(0, 18);
        noise = {$urandom, $urandom};
        c     = ctx;
        // context is only sampled on the closing beat, so scramble it elsewhere
        if (!last && !nof) c = noise[$bits(t_ctx)-1:0];
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, c.must_show, c.sound_on, c.pres_dropping,
                          c.ff_active, c.dirty_gen, c.geom_changed, stated, px};
        s_axis_tlast  <= last;
        s_axis_tuser  <= nof;
        do @(posedge i_clk); while (!s_axis_tready);
        beats_sent++;
    endtask

    // sends count beats of img (random bytes past its end); closing marks the final one
    task automatic send_frame(input logic [23:0] stated, input int count, input bit closing);
        bit          scramble;
        logic [23:0] sz;
        scramble = ($urandom_range(0, 2) == 0);
        for (int p = 0; p < count; p++) begin
            sz = (p != 0 && scramble) ? 24'($urandom) : stated;
            push_beat((p < img.size()) ? img[p] : 8'($urandom), sz,
                      closing && (p == count - 1), 1'b0);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (verdicts_owed != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic random_frame();
        int          roll;
        int          pick;
        int          size;
        int          count;
        logic [23:0] stated;
        roll      = $urandom_range(0, 99);
        tx_steady = ($urandom_range(0, 4) == 0);
        // mostly clean context so that skips stay reachable
        ctx.geom_changed  = ($urandom_range(0, 9) == 0);
        ctx.ff_active     = ($urandom_range(0, 9) == 0);
        ctx.pres_dropping = ($urandom_range(0, 9) == 0);
        ctx.sound_on      = ($urandom_range(0, 9) != 0);
        ctx.must_show     = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 9) == 0) ctx.dirty_gen = $urandom;
        if (roll < 6) begin
            push_beat(8'($urandom), 24'($urandom), 1'($urandom), 1'b1);
            return;
        end
        size = img.size();
        if (size == 0 || $urandom_range(0, 99) < 15) begin
            pick = $urandom_range(0, 49);
            size = (pick == 0) ? $urandom_range(200, 600) :
                   (pick < 8)  ? $urandom_range(13, 64) : $urandom_range(1, 12);
        end
        if (size != img.size()) begin
            img = new[size];
            foreach (img[i]) img[i] = 8'($urandom);
        end else begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
                foreach (img[i]) img[i] = 8'($urandom);
            else if (pick < 5)
                img[$urandom_range(0, size - 1)] = 8'($urandom);
        end
        stated = 24'(size);
        count  = size;
        if (roll < 10) begin
            // stated size of zero or beyond capacity
            stated = $urandom_range(0, 1) ? 24'd0 : 24'($urandom_range(CAPACITY + 1, 24'hFFFFFF));
            count  = $urandom_range(1, 3);
        end else if (roll < 16) begin
            count = size + $urandom_range(1, 3);
        end else if (roll < 22 && size > 1) begin
            count = $urandom_range(1, size - 1);
        end else if (roll < 27 && size > 1) begin
            // abandoned part way by a frame without data
            send_frame(stated, $urandom_range(1, size - 1), 1'b0);
            push_beat(8'($urandom), 24'($urandom), 1'($urandom), 1'b1);
            return;
        end
        send_frame(stated, count, 1'b1);
        if ($urandom_range(0, 39) == 0) drain();
    endtask

    initial begin
        int              goal;
        logic            en;
        logic [7:0]      cap;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        ctx           = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: streak, forced present, generation change, bad sizes
        apb_write(ADDR_SKIP_ENABLE, 32'd1);
        apb_write(ADDR_MAX_STREAK, 32'd2);
        ctx.sound_on  = 1'b1;
        ctx.dirty_gen = 32'hFFFF_FFFF;
        push_beat(8'hA5, 24'd3, 1'b1, 1'b1);       // no data wins over last
        img = new[3];
        img = '{8'h00, 8'hFF, 8'h5A};
        send_frame(24'd3, 3, 1'b1);
        send_frame(24'd3, 3, 1'b1);
        ctx.must_show = 1'b1;
        send_frame(24'd3, 3, 1'b1);
        ctx.must_show = 1'b0;
        ctx.dirty_gen = 32'h0000_0000;
        send_frame(24'd3, 3, 1'b1);
        send_frame(24'd3, 3, 1'b1);
        push_beat(8'h00, 24'd0, 1'b1, 1'b0);
        push_beat(8'hFF, 24'hFF_FFFF, 1'b1, 1'b0);
        push_beat(8'h01, 24'(CAPACITY + 1), 1'b1, 1'b0);
        img = new[2];
        img = '{8'h3C, 8'hC3};
        send_frame(24'd2, 3, 1'b1);
        drain();

        // receiver holds off while single-beat frames pile up behind it
        tx_steady = 1'b1;
        rx_hold = 1'b1;
        repeat (40) push_beat(8'($urandom), 24'd1, 1'b1, 1'b0);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       begin en = 1'b0; cap = 8'd255; end
                1:       begin en = 1'b1; cap = 8'd255; end
                2:       begin en = 1'b1; cap = 8'd0;   end
                3:       begin en = 1'b1; cap = 8'd1;   end
                4:       begin en = 1'b1; cap = 8'd3;   end
                default: begin en = 1'b1; cap = 8'($urandom_range(2, 254)); end
            endcase
            drain();
            apb_write(ADDR_SKIP_ENABLE, {31'd0, en});
            apb_write(ADDR_MAX_STREAK, {24'd0, cap});
            rx_steady = (ph == 3);
            goal = beats_sent + RANDOM_BEATS / PHASES;
            while (beats_sent < goal) random_frame();
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && verdicts_owed == 0)
            $display("duplicate_frame_skip_detector_tb: done, clean");
        else
            $display("duplicate_frame_skip_detector_tb: done, errors");
        $finish;
    end

endmodule
